// ===== sv/rrwf_pkg.sv =====
`default_nettype none

package rrwf_pkg;

   // field widths
   localparam int COL_W   = 12;
   localparam int PIXEL_W = 8;
   localparam int CSR_IDX_W = 8;

   // longest row the column counter ever walks
   localparam int LINE_PIXELS_MAX = 4096;

   // pixel codes
   localparam logic [PIXEL_W-1:0] PIXEL_RUN_START = 8'd255;
   localparam logic [PIXEL_W-1:0] PIXEL_RUN_END   = 8'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RUN_WIDTH = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RUN_WIDTH = 8'd3;

   // register reset values
   localparam logic [COL_W-1:0] FRAME_WIDTH_RESET   = 12'd640;
   localparam logic [COL_W-1:0] FRAME_HEIGHT_RESET  = 12'd480;
   localparam logic [COL_W-1:0] MIN_RUN_WIDTH_RESET = 12'd5;
   localparam logic [COL_W-1:0] MAX_RUN_WIDTH_RESET = 12'd40;

   typedef struct packed {
      logic [COL_W-1:0] frame_width;
      logic [COL_W-1:0] frame_height;
      logic [COL_W-1:0] min_width;
      logic [COL_W-1:0] max_width;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] row;
      logic [COL_W-1:0] start_col;
      logic [COL_W-1:0] end_col;
      logic [COL_W-1:0] mid_col;
   } run_type;

endpackage

`default_nettype wire

// ===== sv/rrwf_csr.sv =====
`default_nettype none

module rrwf_csr
   import rrwf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [CSR_IDX_W-1:0] wr_index,
   input  wire logic [COL_W-1:0]     wr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write; unknown indexes leave everything as it is
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_FRAME_WIDTH:   cfg_in.frame_width  = wr_data;
            CSR_FRAME_HEIGHT:  cfg_in.frame_height = wr_data;
            CSR_MIN_RUN_WIDTH: cfg_in.min_width    = wr_data;
            CSR_MAX_RUN_WIDTH: cfg_in.max_width    = wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= FRAME_WIDTH_RESET;
         cfg_ff.frame_height <= FRAME_HEIGHT_RESET;
         cfg_ff.min_width    <= MIN_RUN_WIDTH_RESET;
         cfg_ff.max_width    <= MAX_RUN_WIDTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/rrwf_tracker.sv =====
`default_nettype none

module rrwf_tracker
   import rrwf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               step,
   input  wire logic [PIXEL_W-1:0] pixel,
   input  wire logic               res_stall,
   output logic                    accept,
   output logic                    res_valid,
   output run_type                 res
);

   logic [COL_W-1:0] col_ff,    col_in;
   logic [COL_W-1:0] row_ff,    row_in;
   logic             active_ff, active_in;
   logic [COL_W-1:0] start_ff,  start_in;
   logic             valid_ff,  valid_in;
   run_type          res_ff,    res_in;

   logic [COL_W:0]   col_next;
   logic [COL_W:0]   row_next;
   logic [COL_W:0]   mid_sum;
   logic [COL_W-1:0] run_span;
   logic             last;
   logic             ending;
   logic             starting;
   logic             hit;

   // result register frees up when empty or taken
   assign accept = !valid_ff || !res_stall;

   // classify the current column and pixel
   always_comb begin
      col_next = {1'b0, col_ff} + 1'b1;
      row_next = {1'b0, row_ff} + 1'b1;
      mid_sum  = {1'b0, start_ff} + {1'b0, col_ff};
      run_span = col_ff - start_ff;
      last     = (col_next >= {1'b0, cfg.frame_width})
               || ({{(32-COL_W-1){1'b0}}, col_next} >= 32'(LINE_PIXELS_MAX));
      ending   = active_ff && ((pixel == PIXEL_RUN_END) || last);
      starting = !active_ff && (pixel == PIXEL_RUN_START) && !last;
      hit      = ending && (run_span >= cfg.min_width) && (run_span <= cfg.max_width);
   end

   // advance the run state and the counters on each item
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      active_in = active_ff;
      start_in  = start_ff;
      if (step) begin
         if (ending) begin
            active_in = 1'b0;
         end else if (starting) begin
            active_in = 1'b1;
            start_in  = col_ff;
         end
         if (last) begin
            col_in = '0;
            row_in = (row_next >= {1'b0, cfg.frame_height}) ? '0 : row_next[COL_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   // load the result register
   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (accept) begin
         valid_in = step && hit;
         if (step && hit) begin
            res_in.row       = row_ff;
            res_in.start_col = start_ff;
            res_in.end_col   = col_ff;
            res_in.mid_col   = mid_sum[COL_W:1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         active_ff <= 1'b0;
         start_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         active_ff <= active_in;
         start_ff  <= start_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res_valid = valid_ff;
   assign res       = res_ff;

endmodule

`default_nettype wire

// ===== sv/row_run_width_filter.sv =====
`default_nettype none

// Row run width filter. Pixels arrive one per item, left to right and row by
// row; a run opens at a 255 pixel (never in the last column) and closes at the
// next 0 pixel or at the last column of the row. A run whose end minus start
// lies within min_run_width..max_run_width gives one item on the rsp_ side
// with row, start, end and truncated midpoint. One pixel is taken per clock
// while no held result stalls it; an item passes an input register and then
// the run tracker with its result register, from which its result is offered,
// and the only stall on req_ comes back from a held result. Registers (index 0 to
// 3: frame_width, frame_height, min_run_width, max_run_width) are written over
// csr_, which is always ready; writes take effect at once and are to be made
// while no pixel is in flight.
module row_run_width_filter
   import rrwf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [PIXEL_W-1:0]   req_pixel_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [COL_W-1:0]          rsp_run_row,
   output logic [COL_W-1:0]          rsp_run_start,
   output logic [COL_W-1:0]          rsp_run_end,
   output logic [COL_W-1:0]          rsp_run_middle,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COL_W-1:0]     csr_wdata
);

   cfg_type            cfg;
   run_type            res;
   logic               accept;
   logic               step;
   logic               pix_valid_ff, pix_valid_in;
   logic [PIXEL_W-1:0] pixel_ff,     pixel_in;

   assign csr_ready = 1'b1;

   rrwf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // input register: hold while the tracker cannot take the item
   assign req_stall = pix_valid_ff && !accept;
   assign step      = pix_valid_ff && accept;

   always_comb begin
      pix_valid_in = pix_valid_ff;
      pixel_in     = pixel_ff;
      if (!req_stall) begin
         pix_valid_in = req_valid;
         pixel_in     = req_pixel_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   rrwf_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .pixel     (pixel_ff),
      .res_stall (rsp_stall),
      .accept    (accept),
      .res_valid (rsp_valid),
      .res       (res)
   );

   assign rsp_run_row    = res.row;
   assign rsp_run_start  = res.start_col;
   assign rsp_run_end    = res.end_col;
   assign rsp_run_middle = res.mid_col;

   // a run always closes to the right of where it opened
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_end > rsp_run_start))
      else $error("run end not beyond run start");

   // the midpoint lies within the run
   a_mid_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_middle >= rsp_run_start && rsp_run_middle <= rsp_run_end))
      else $error("run midpoint outside the run");

   // the input side stalls only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && pix_valid_ff))
      else $error("input stalled without a held result");

   // a stalled pixel is still pending in the next cycle
   a_pixel_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> (pix_valid_ff && $stable(pixel_ff)))
      else $error("stalled pixel lost");

endmodule

`default_nettype wire

// ===== tb/sv/row_run_width_filter_tb.sv =====
`default_nettype none

module row_run_width_filter_tb;
   import rrwf_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PRINT_LIMIT   = 40;
   localparam int MODE_STRETCH  = 60;
   localparam int HOLD_CYCLES   = 150;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // block inputs, all known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic [PIXEL_W-1:0]   req_pixel_value = '0;
   logic                 rsp_stall = 1'b0;
   logic                 csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COL_W-1:0]     csr_wdata = '0;

   // block outputs
   logic                 req_stall;
   logic                 rsp_valid;
   logic [COL_W-1:0]     rsp_run_row;
   logic [COL_W-1:0]     rsp_run_start;
   logic [COL_W-1:0]     rsp_run_end;
   logic [COL_W-1:0]     rsp_run_middle;
   logic                 csr_ready;

   // shadow of the registers and of the run tracker
   cfg_type          frame_cfg = {FRAME_WIDTH_RESET, FRAME_HEIGHT_RESET,
                                  MIN_RUN_WIDTH_RESET, MAX_RUN_WIDTH_RESET};
   logic [COL_W-1:0] col_pos   = '0;
   logic [COL_W-1:0] row_pos   = '0;
   logic             run_open  = 1'b0;
   logic [COL_W-1:0] run_begin = '0;

   run_type expected_runs[$];
   int      mismatch_count = 0;
   int      send_idle_pct  = 0;
   int      rsp_stall_pct  = 0;
   int      hold_off_left  = 0;
   int      random_items   = 0;
   int      quiet_cycles   = 0;

   row_run_width_filter i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_run_row     (rsp_run_row),
      .rsp_run_start   (rsp_run_start),
      .rsp_run_end     (rsp_run_end),
      .rsp_run_middle  (rsp_run_middle),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // advance the run tracker by one pixel; return 1 when a run qualifies
   function automatic bit track_pixel(input logic [PIXEL_W-1:0] px, output run_type found);
      logic [COL_W:0]   next_col;
      logic [COL_W:0]   next_row;
      logic [COL_W:0]   mid_sum;
      logic [COL_W-1:0] run_span;
      bit               at_last;
      bit               hit;
      found    = '0;
      hit      = 1'b0;
      next_col = {1'b0, col_pos} + 1'b1;
      at_last  = (next_col >= {1'b0, frame_cfg.frame_width}) ||
                 (next_col >= LINE_PIXELS_MAX);
      if (run_open) begin
         if (px == PIXEL_RUN_END || at_last) begin
            run_span = col_pos - run_begin;
            run_open = 1'b0;
            if (run_span >= frame_cfg.min_width && run_span <= frame_cfg.max_width) begin
               mid_sum         = {1'b0, run_begin} + {1'b0, col_pos};
               found.row       = row_pos;
               found.start_col = run_begin;
               found.end_col   = col_pos;
               found.mid_col   = mid_sum[COL_W:1];
               hit             = 1'b1;
            end
         end
      end else if (px == PIXEL_RUN_START && !at_last) begin
         run_begin = col_pos;
         run_open  = 1'b1;
      end
      // step the column, wrap the row at the frame height
      if (at_last) begin
         col_pos  = '0;
         next_row = {1'b0, row_pos} + 1'b1;
         if (next_row >= {1'b0, frame_cfg.frame_height})
            row_pos = '0;
         else
            row_pos = next_row[COL_W-1:0];
      end else begin
         col_pos = next_col[COL_W-1:0];
      end
      return hit;
   endfunction

   function automatic void set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 79;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            rsp_stall_pct = 79;
         end
         default: begin
            send_idle_pct = 16;
            rsp_stall_pct = 16;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // offer one pixel, hold it while stalled, predict once it is taken
   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      run_type found;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= px;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (track_pixel(px, found))
         expected_runs = {expected_runs, found};
   endtask

   // drop valid, wait for every run, then let the last pixel clear the pipe
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_runs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [COL_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_FRAME_WIDTH:   frame_cfg.frame_width  = data;
         CSR_FRAME_HEIGHT:  frame_cfg.frame_height = data;
         CSR_MIN_RUN_WIDTH: frame_cfg.min_width    = data;
         CSR_MAX_RUN_WIDTH: frame_cfg.max_width    = data;
         default: ;
      endcase
   endtask

   // write all four registers plus one index that the block must ignore
   task automatic program_frame(input int width, input int height,
                                input int min_w, input int max_w);
      write_register(CSR_FRAME_WIDTH, COL_W'(width));
      write_register(8'($urandom_range(255, 4)), 12'($urandom));
      write_register(CSR_FRAME_HEIGHT, COL_W'(height));
      write_register(CSR_MIN_RUN_WIDTH, COL_W'(min_w));
      write_register(CSR_MAX_RUN_WIDTH, COL_W'(max_w));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed runs of random length and content, some noise
   task automatic send_random_stretch(input int len_lo, input int len_hi,
                                      input int count, input bit vary_idle);
      int sent;
      int len;
      int noise;
      sent = 0;
      while (sent < count) begin
         if (vary_idle)
            set_idle_mode(idle_mode_type'((random_items / MODE_STRETCH) % 4));
         if ($urandom_range(99) < 30) begin
            noise = $urandom_range(4, 1);
            repeat (noise) send_pixel(PIXEL_W'($urandom_range(255, 0)));
            sent += noise;
            random_items += noise;
         end else begin
            len = $urandom_range(len_hi, len_lo);
            send_pixel(PIXEL_RUN_START);
            for (int i = 1; i < len; i++) begin
               if ($urandom_range(99) < 20)
                  send_pixel(PIXEL_RUN_START);
               else
                  send_pixel(PIXEL_W'($urandom_range(254, 1)));
            end
            send_pixel(PIXEL_RUN_END);
            sent += len + 1;
            random_items += len + 1;
         end
      end
   endtask

   task automatic run_frame_phase(input int width, input int height, input int min_w,
                                  input int max_w, input int len_lo, input int len_hi,
                                  input int count);
      drain_pipeline();
      program_frame(width, height, min_w, max_w);
      send_random_stretch(len_lo, len_hi, count, 1'b1);
   endtask

   // hand-picked rows: window edges, runs cut by the last column, row wrap
   task automatic test_directed_runs();
      set_idle_mode(IDLE_NONE);
      // reset settings: a run of width five qualifies, one of three does not
      send_pixel(PIXEL_RUN_START);
      send_pixel(8'd128);
      send_pixel(8'd1);
      send_pixel(8'd254);
      send_pixel(PIXEL_RUN_START);
      send_pixel(PIXEL_RUN_END);
      send_pixel(PIXEL_RUN_START);
      send_pixel(8'h55);
      send_pixel(8'hAA);
      send_pixel(PIXEL_RUN_END);
      drain_pipeline();
      // shrink the row under the current column
      program_frame(8, 2, 0, 7);
      send_pixel(PIXEL_RUN_END);
      // row one: shortest run, then a run closed by the last column
      send_pixel(PIXEL_RUN_START);
      send_pixel(PIXEL_RUN_END);
      send_pixel(PIXEL_RUN_START);
      send_pixel(8'd17);
      send_pixel(8'd240);
      send_pixel(PIXEL_RUN_START);
      send_pixel(8'd99);
      send_pixel(8'd200);
      // row wrapped to zero: a start pixel in the last column is ignored
      repeat (7) send_pixel(PIXEL_RUN_END);
      send_pixel(PIXEL_RUN_START);
   endtask

   task automatic test_random_frames();
      run_frame_phase(16,   5,    2,    6,    1, 8,   220);
      run_frame_phase(33,   7,    1,    1,    1, 3,   180);
      run_frame_phase(1,    1,    0,    4095, 1, 4,   30);
      run_frame_phase(0,    0,    4095, 0,    1, 4,   30);
      run_frame_phase(64,   3,    10,   3,    1, 12,  60);
      run_frame_phase(4095, 4095, 0,    4095, 1, 60,  200);
      run_frame_phase(12,   4095, 3,    9,    2, 11,  220);
      run_frame_phase(20,   2,    0,    19,   1, 20,  180);
   endtask

   // hold the result side off for a long stretch while pixels keep coming
   task automatic test_backpressure();
      drain_pipeline();
      program_frame(10, 4, 0, 9);
      set_idle_mode(IDLE_NONE);
      hold_off_left = HOLD_CYCLES;
      send_random_stretch(1, 4, 120, 1'b0);
   endtask

   // result side: stall at random or for the requested hold-off
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // compare each accepted run with the oldest prediction
   always @(posedge clock) begin : run_check
      run_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_runs.size() == 0) begin
            report_mismatch($sformatf("unexpected run row %0d start %0d end %0d mid %0d",
                                      rsp_run_row, rsp_run_start, rsp_run_end,
                                      rsp_run_middle));
         end else begin
            want = expected_runs.pop_front();
            if (rsp_run_row !== want.row)
               report_mismatch($sformatf("run_row got %0d want %0d",
                                         rsp_run_row, want.row));
            if (rsp_run_start !== want.start_col)
               report_mismatch($sformatf("run_start got %0d want %0d",
                                         rsp_run_start, want.start_col));
            if (rsp_run_end !== want.end_col)
               report_mismatch($sformatf("run_end got %0d want %0d",
                                         rsp_run_end, want.end_col));
            if (rsp_run_middle !== want.mid_col)
               report_mismatch($sformatf("run_middle got %0d want %0d",
                                         rsp_run_middle, want.mid_col));
         end
      end
   end

   // end the run when no item moves on any channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_runs();
      test_random_frames();
      test_backpressure();
      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
